// File: rtl/arss_pkg.sv
// Package for the auto-range sensor scaler: request/result types and constants.
`default_nettype none
package arss_pkg;

  localparam int unsigned NumChannelsDef = 256;
  localparam int unsigned SampleBitsDef  = 16;
  localparam int unsigned ScaleTop       = 255;
  localparam int unsigned PercentMax     = 100;
  localparam logic [15:0] MinSpanReset   = 16'd500;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_DAMPEN = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  channel;
    logic [15:0] sample_value;
    logic [7:0]  dampen_amount;
  } in_t;

  typedef struct packed {
    logic [7:0] scaled_value;
    logic [7:0] channel_echo;
  } out_t;

endpackage
`default_nettype wire

// File: rtl/arss_mark_mem.sv
// Mark memory: low and high mark per channel, one read and one write port.
`default_nettype none
module arss_mark_mem import arss_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef,
  parameter int unsigned SAMPLE_BITS  = SampleBitsDef,
  localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output logic      [2*SAMPLE_BITS-1:0] rd_data,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [2*SAMPLE_BITS-1:0] wr_data
);

  logic [2*SAMPLE_BITS-1:0] mem [NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/arss_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module arss_divider import arss_pkg::*; #(
  parameter int unsigned NW = SampleBitsDef + 8,
  parameter int unsigned DW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic      [NW-1:0] quo
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, num_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= CW'(NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
        num_r <= {num_r[NW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule
`default_nettype wire

// File: rtl/auto_range_sensor_scaler_top.sv
// Top level of the auto-range sensor scaler: sequencer around the mark memory.
// One request is worked at a time. A sample reads the channel's marks, widens
// them to the sample, writes them back and has the bit-serial divider form
// offset*255/span. A dampen walks every channel through the memory: a channel
// whose marks do not span is only read, one that does is narrowed (multiply,
// reciprocal multiply by 1/100, write back). A clear writes one channel a cycle.
// After reset a clearing pass over all channels runs before the first request
// is taken; configuration writes are taken at any time.
`default_nettype none
module auto_range_sensor_scaler_top import arss_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef,
  parameter int unsigned SAMPLE_BITS  = SampleBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned NW = SB + 8;
  localparam int unsigned DW = (SB > 16) ? SB : 16;
  localparam int unsigned RK = SB + 14;
  localparam logic [SB-1:0] FullScale = {SB{1'b1}};
  localparam logic [AW-1:0] LastIdx   = AW'(NUM_CHANNELS - 1);
  localparam logic [SB+7:0] RecipM    = (SB+8)'(((64'd1 << RK) + 64'd99) / 64'd100);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_SUPD, S_SDIV, S_DUPD, S_DSTART, S_DDIV, S_OUT
  } state_t;

  state_t        state_r;
  logic [AW-1:0] idx_r;
  in_t           req_r;
  logic [6:0]    amt_r;
  logic [SB-1:0] val_r;
  logic [SB-1:0] lo_r;
  logic [SB-1:0] hi_r;
  logic [SB-1:0] span_r;
  logic [SB+6:0] prod_r;
  logic [SB-1:0] quo_r;
  logic [7:0]    res_r;
  logic          report_r;
  logic          out_valid_r;
  out_t          out_data_r;
  logic [15:0]   min_span_r;

  logic [2*SB-1:0] rd_data;
  logic            mem_rd_en;
  logic            mem_wr_en;
  logic [2*SB-1:0] mem_wr_data;
  logic [SB-1:0]   rd_lo;
  logic [SB-1:0]   rd_hi;
  logic [SB-1:0]   new_lo;
  logic [SB-1:0]   new_hi;
  logic [SB-1:0]   offset;
  logic [DW-1:0]   true_span;
  logic [DW-1:0]   samp_den;
  logic [NW-1:0]   samp_num;
  logic [SB-1:0]   rd_diff;
  logic [SB-1:0]   amt_w;
  logic [SB-1:0]   cut;
  logic [2*SB+14:0] recip_prod;
  logic            div_start;
  logic [NW-1:0]   div_num;
  logic [DW-1:0]   div_den;
  logic            div_done;
  logic [NW-1:0]   div_quo;

  assign rd_lo    = rd_data[2*SB-1:SB];
  assign rd_hi    = rd_data[SB-1:0];
  assign new_lo   = (val_r < rd_lo) ? val_r : rd_lo;
  assign new_hi   = (val_r > rd_hi) ? val_r : rd_hi;
  assign offset   = val_r - new_lo;
  assign true_span = DW'(new_hi - new_lo);
  assign samp_den = (true_span < DW'(min_span_r)) ? DW'(min_span_r) : true_span;
  assign samp_num = (NW'(offset) << 8) - NW'(offset);
  assign rd_diff  = rd_hi - rd_lo;
  assign amt_w    = SB'(amt_r);
  assign recip_prod = prod_r * RecipM;
  assign cut      = (quo_r < amt_w) ? ((amt_w < span_r) ? amt_w : span_r) : quo_r;

  always_comb begin
    mem_rd_en   = (state_r == S_RD);
    mem_wr_en   = 1'b0;
    mem_wr_data = {lo_r + cut, hi_r - cut};
    div_start   = 1'b0;
    div_num     = samp_num;
    div_den     = samp_den;
    case (state_r)
      S_CLR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {FullScale, {SB{1'b0}}};
      end
      S_SUPD: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {new_lo, new_hi};
        div_start   = 1'b1;
      end
      S_DDIV: begin
        mem_wr_en = 1'b1;
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  arss_mark_mem #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mem (
    .clk    (clk),
    .rd_en  (mem_rd_en),
    .rd_addr(idx_r),
    .rd_data(rd_data),
    .wr_en  (mem_wr_en),
    .wr_addr(idx_r),
    .wr_data(mem_wr_data)
  );

  arss_divider #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
      min_span_r  <= MinSpanReset;
    end else begin
      if (cfg_valid) begin
        min_span_r <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
      end
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          if (idx_r == LastIdx) begin
            res_r   <= '0;
            state_r <= report_r ? S_OUT : S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_r <= in_data;
            amt_r <= (in_data.dampen_amount > 8'(PercentMax)) ? 7'(PercentMax)
                                                             : in_data.dampen_amount[6:0];
            val_r <= SB'(in_data.sample_value);
            res_r <= '0;
            case (in_data.opcode)
              OP_SAMPLE: begin
                if (32'(in_data.channel) < 32'(NUM_CHANNELS)) begin
                  idx_r   <= AW'(in_data.channel);
                  state_r <= S_RD;
                end else begin
                  state_r <= S_OUT;
                end
              end
              OP_DAMPEN: begin
                idx_r   <= '0;
                state_r <= S_RD;
              end
              OP_CLEAR: begin
                idx_r    <= '0;
                report_r <= 1'b1;
                state_r  <= S_CLR;
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= (req_r.opcode == OP_SAMPLE) ? S_SUPD : S_DUPD;
        end
        S_SUPD: begin
          state_r <= S_SDIV;
        end
        S_SDIV: begin
          if (div_done) begin
            res_r   <= div_quo[7:0];
            state_r <= S_OUT;
          end
        end
        S_DUPD: begin
          lo_r   <= rd_lo;
          hi_r   <= rd_hi;
          span_r <= rd_diff;
          prod_r <= rd_diff * amt_r;
          if (rd_lo < rd_hi) begin
            state_r <= S_DSTART;
          end else if (idx_r == LastIdx) begin
            state_r <= S_OUT;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_DSTART: begin
          quo_r   <= recip_prod[RK +: SB];
          state_r <= S_DDIV;
        end
        S_DDIV: begin
          if (idx_r == LastIdx) begin
            state_r <= S_OUT;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{scaled_value: res_r, channel_echo: req_r.channel};
            report_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_SDIV))
    else $error("divider finished outside the sample division state");

  a_sample_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (div_done && state_r == S_SDIV) |-> (div_quo[NW-1:8] == '0))
    else $error("scaled sample exceeds eight bits");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (state_r == S_CLR || state_r == S_SUPD || state_r == S_DDIV))
    else $error("mark write outside an update state");

  a_idle_no_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUPD) |=> (state_r == S_SDIV))
    else $error("sample update did not enter division");

endmodule
`default_nettype wire
